>>> hw/rtl/cpt_pkg.sv
// shared types, constants and helpers for the clip-region point test
// no dependencies; used by cpt_ctrl, cpt_dpath and csg_clip_point_test
package cpt_pkg;

    localparam int MAX_CLIPS      = 16;
    localparam int WORDS_PER_CLIP = 12;
    localparam int WORDS_TOTAL    = MAX_CLIPS * WORDS_PER_CLIP;

    // word slots inside one entry
    localparam logic [3:0] W_CENTER = 4'd0;
    localparam logic [3:0] W_NORMAL = 4'd3;
    localparam logic [3:0] W_APEX   = 4'd6;
    localparam logic [3:0] W_R1     = 4'd9;
    localparam logic [3:0] W_R2     = 4'd10;
    localparam logic [3:0] W_LEN    = 4'd11;

    // word_select code for the type field
    localparam logic [3:0] WS_TYPE = 4'd0;

    // type bits
    localparam int T_PLANE  = 0;
    localparam int T_SPHERE = 1;
    localparam int T_CONE   = 2;
    localparam int T_INSIDE = 3;

    localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
    localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

    typedef struct packed {
        logic               kind;
        logic [3:0]         clip_index;
        logic [3:0]         word_select;
        logic signed [31:0] word_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_beat_t;

    typedef struct packed {
        logic visible;
        logic bad_type;
    } out_beat_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LD_VC,
        OP_LD_VV,
        OP_LD_AN,
        OP_LD_RP,
        OP_LD_RR,
        OP_LD_TN,
        OP_LD_DD,
        OP_MUL,
        OP_ACC,
        OP_SAVE_DOT,
        OP_DIV,
        OP_R,
        OP_SAVE_RR,
        OP_AXIS
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic       clr;
        logic       rd_en;
        logic [3:0] rd_word;
        logic [3:0] entry;
        logic       take_point;
        logic       load;
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] type_bits;
        logic       neg;
        logic       gt_len;
        logic       gt_r1;
        logic       lt_r1;
        logic       gt_rr;
        logic       lt_rr;
    } dp_status_t;

    // clamp to signed 32-bit
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/cpt_dpath.sv
// datapath of the clip-region point test: clip table, word buffer,
// shared multiplier, accumulator and radial divider; uses cpt_pkg
module cpt_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  cpt_pkg::in_beat_t in_data,
    input  cpt_pkg::dp_cmd_t  cmd,
    output cpt_pkg::dp_status_t status
);
    import cpt_pkg::*;

    logic [31:0]        mem [WORDS_TOTAL];
    logic [3:0]         type_mem [MAX_CLIPS];
    logic [31:0]        rd_data_reg;
    logic               rd_en_d_reg;
    logic [3:0]         rd_word_d_reg;
    logic signed [31:0] w_reg [WORDS_PER_CLIP];
    logic signed [31:0] p_reg [3];
    logic signed [33:0] ma_reg;
    logic signed [33:0] mb_reg;
    logic signed [49:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic [30:0]        dot_reg;
    logic [32:0]        rem_reg;
    logic [16:0]        q_reg;
    logic signed [31:0] r_reg;
    logic signed [49:0] rr_reg;
    logic signed [50:0] axis_reg;

    logic [7:0]         wr_addr;
    logic [7:0]         rd_addr;
    logic signed [67:0] mul_full;
    logic signed [31:0] p_sel;
    logic signed [31:0] c_sel;
    logic signed [31:0] n_sel;
    logic signed [31:0] a_sel;
    logic signed [31:0] diff_c;
    logic signed [31:0] diff_a;
    logic signed [31:0] diff_d;
    logic [32:0]        len_ext;
    logic               div_ge;
    logic [32:0]        rem_sub;
    logic [16:0]        pct;

    // table addressing: entry * 12 + word
    assign wr_addr = 8'({in_data.clip_index, 3'b000}) + 8'({in_data.clip_index, 2'b00})
                   + 8'(in_data.word_select) - 8'd1;
    assign rd_addr = 8'({cmd.entry, 3'b000}) + 8'({cmd.entry, 2'b00}) + 8'(cmd.rd_word);

    // operand selection
    assign p_sel  = p_reg[cmd.idx];
    assign c_sel  = w_reg[W_CENTER + 4'(cmd.idx)];
    assign n_sel  = w_reg[W_NORMAL + 4'(cmd.idx)];
    assign a_sel  = w_reg[W_APEX + 4'(cmd.idx)];
    assign diff_c = sat32(52'(p_sel) - 52'(c_sel));
    assign diff_a = sat32(52'(p_sel) - 52'(a_sel));
    assign diff_d = sat32(52'(axis_reg) - 52'(p_sel));

    // shared multiplier
    assign mul_full = ma_reg * mb_reg;

    // restoring divider step
    assign len_ext = {2'b00, w_reg[W_LEN][30:0]};
    assign div_ge  = rem_reg >= len_ext;
    assign rem_sub = div_ge ? rem_reg - len_ext : rem_reg;
    assign pct     = (w_reg[W_LEN] == 32'sd0) ? 17'd0 : q_reg;

    // table writes and word fetch
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.word_select == WS_TYPE)
            type_mem[in_data.clip_index] <= in_data.word_value[3:0];
        if (cmd.load && (in_data.word_select inside {[4'd1:4'd12]}))
            mem[wr_addr] <= in_data.word_value;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (rd_en_d_reg)
            w_reg[rd_word_d_reg] <= rd_data_reg;
        rd_word_d_reg <= cmd.rd_word;
    end

    // fetch valid delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_en_d_reg <= 1'b0;
        else
            rd_en_d_reg <= cmd.rd_en;
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_point)
        begin
            p_reg[0] <= in_data.point_x;
            p_reg[1] <= in_data.point_y;
            p_reg[2] <= in_data.point_z;
        end
        if (cmd.clr)
            acc_reg <= '0;
        case (cmd.op)
            OP_LD_VC:
            begin
                ma_reg <= 34'(diff_c);
                mb_reg <= 34'(n_sel);
            end
            OP_LD_VV:
            begin
                ma_reg <= 34'(diff_c);
                mb_reg <= 34'(diff_c);
            end
            OP_LD_AN:
            begin
                ma_reg <= 34'(diff_a);
                mb_reg <= 34'(n_sel);
            end
            OP_LD_RP:
            begin
                ma_reg <= 34'(w_reg[W_R2]) - 34'(w_reg[W_R1]);
                mb_reg <= $signed({17'd0, pct});
            end
            OP_LD_RR:
            begin
                ma_reg <= 34'(r_reg);
                mb_reg <= 34'(r_reg);
            end
            OP_LD_TN:
            begin
                ma_reg <= $signed({3'b000, dot_reg});
                mb_reg <= 34'(n_sel);
            end
            OP_LD_DD:
            begin
                ma_reg <= 34'(diff_d);
                mb_reg <= 34'(diff_d);
            end
            OP_MUL:
                prod_reg <= mul_full[65:16];
            OP_ACC:
                acc_reg <= acc_reg + 52'(prod_reg);
            OP_SAVE_DOT:
            begin
                dot_reg <= acc_reg[30:0];
                rem_reg <= {2'b00, acc_reg[30:0]};
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= {rem_sub[31:0], 1'b0};
                q_reg   <= {q_reg[15:0], div_ge};
            end
            OP_R:
                r_reg <= sat32(52'(w_reg[W_R1]) + 52'(prod_reg));
            OP_SAVE_RR:
                rr_reg <= prod_reg;
            OP_AXIS:
                axis_reg <= 51'(a_sel) + 51'(prod_reg);
            default:
            begin
            end
        endcase
    end

    // status back to the controller
    always_comb
    begin
        status.type_bits = type_mem[cmd.entry];
        status.neg       = acc_reg < 52'sd0;
        status.gt_len    = acc_reg > 52'(w_reg[W_LEN]);
        status.gt_r1     = acc_reg > 52'(w_reg[W_R1]);
        status.lt_r1     = acc_reg < 52'(w_reg[W_R1]);
        status.gt_rr     = acc_reg > 52'(rr_reg);
        status.lt_rr     = acc_reg < 52'(rr_reg);
    end

endmodule

>>> hw/rtl/cpt_ctrl.sv
// controller of the clip-region point test: entry walk sequencer,
// clip_count register and result register; uses cpt_pkg
module cpt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_kind,
    input  logic                cfg_wr_en,
    input  logic [4:0]          cfg_wr_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cpt_pkg::out_beat_t  out_data,
    output cpt_pkg::dp_cmd_t    cmd,
    input  cpt_pkg::dp_status_t status
);
    import cpt_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FETCH  = 10'b0000000010,
        S_DISP   = 10'b0000000100,
        S_DOT    = 10'b0000001000,
        S_CHK_T  = 10'b0000010000,
        S_DIV    = 10'b0000100000,
        S_RAD    = 10'b0001000000,
        S_DIST   = 10'b0010000000,
        S_DECIDE = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        SH_PLANE,
        SH_SPHERE,
        SH_CONE
    } shape_t;

    state_t     state_reg, state_next;
    shape_t     shape_reg, shape_next;
    logic [4:0] count_reg, count_next;
    logic [4:0] entry_reg, entry_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] ph_reg, ph_next;
    logic [1:0] i_reg, i_next;
    logic       vis_reg, vis_next;
    logic       bad_reg, bad_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_vis_reg, out_vis_next;
    logic       out_bad_reg, out_bad_next;

    logic [4:0] n_eff;
    logic       inside_bit;
    logic       pass_ev;
    logic       fail_ev;
    logic       fail_bad;

    assign n_eff      = (count_reg > 5'(MAX_CLIPS)) ? 5'(MAX_CLIPS) : count_reg;
    assign inside_bit = status.type_bits[T_INSIDE];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = '{visible: out_vis_reg, bad_type: out_bad_reg};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        shape_next     = shape_reg;
        entry_next     = entry_reg;
        cnt_next       = cnt_reg;
        ph_next        = ph_reg;
        i_next         = i_reg;
        vis_next       = vis_reg;
        bad_next       = bad_reg;
        out_vis_next   = out_vis_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !out_ready;
        count_next     = cfg_wr_en ? cfg_wr_data : count_reg;
        pass_ev        = 1'b0;
        fail_ev        = 1'b0;
        fail_bad       = 1'b0;

        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.idx        = i_reg;
        cmd.entry      = entry_reg[3:0];
        cmd.rd_word    = cnt_reg[3:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind)
                    begin
                        cmd.take_point = 1'b1;
                        entry_next     = '0;
                        cnt_next       = '0;
                        if (n_eff == 5'd0)
                        begin
                            vis_next   = 1'b1;
                            bad_next   = 1'b0;
                            state_next = S_FIN;
                        end
                        else
                            state_next = S_FETCH;
                    end
                    else
                        cmd.load = 1'b1;
                end
            end
            S_FETCH:
            begin
                cmd.rd_en = (cnt_reg < 5'(WORDS_PER_CLIP));
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'(WORDS_PER_CLIP))
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                cmd.clr = 1'b1;
                ph_next = '0;
                i_next  = '0;
                if (status.type_bits[T_PLANE])
                begin
                    shape_next = SH_PLANE;
                    state_next = S_DOT;
                end
                else if (status.type_bits[T_SPHERE])
                begin
                    shape_next = SH_SPHERE;
                    state_next = S_DOT;
                end
                else if (status.type_bits[T_CONE])
                begin
                    shape_next = SH_CONE;
                    state_next = S_DOT;
                end
                else
                begin
                    fail_ev  = 1'b1;
                    fail_bad = 1'b1;
                end
            end
            S_DOT:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        case (shape_reg)
                            SH_PLANE:  cmd.op = OP_LD_VC;
                            SH_SPHERE: cmd.op = OP_LD_VV;
                            default:   cmd.op = OP_LD_AN;
                        endcase
                        ph_next = 3'd1;
                    end
                    3'd1:
                    begin
                        cmd.op  = OP_MUL;
                        ph_next = 3'd2;
                    end
                    default:
                    begin
                        cmd.op  = OP_ACC;
                        ph_next = 3'd0;
                        if (i_reg == 2'd2)
                            state_next = (shape_reg == SH_CONE) ? S_CHK_T : S_DECIDE;
                        else
                            i_next = i_reg + 2'd1;
                    end
                endcase
            end
            S_CHK_T:
            begin
                if (status.neg || status.gt_len)
                begin
                    if (inside_bit)
                        fail_ev = 1'b1;
                    else
                        pass_ev = 1'b1;
                end
                else
                begin
                    cmd.op     = OP_SAVE_DOT;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    ph_next    = '0;
                    state_next = S_RAD;
                end
            end
            S_RAD:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd0:
                    begin
                        cmd.op  = OP_LD_RP;
                        cmd.clr = 1'b1;
                    end
                    3'd1: cmd.op = OP_MUL;
                    3'd2: cmd.op = OP_R;
                    3'd3: cmd.op = OP_LD_RR;
                    3'd4: cmd.op = OP_MUL;
                    default:
                    begin
                        cmd.op     = OP_SAVE_RR;
                        ph_next    = '0;
                        i_next     = '0;
                        state_next = S_DIST;
                    end
                endcase
            end
            S_DIST:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd0: cmd.op = OP_LD_TN;
                    3'd1: cmd.op = OP_MUL;
                    3'd2: cmd.op = OP_AXIS;
                    3'd3: cmd.op = OP_LD_DD;
                    3'd4: cmd.op = OP_MUL;
                    default:
                    begin
                        cmd.op  = OP_ACC;
                        ph_next = '0;
                        if (i_reg == 2'd2)
                            state_next = S_DECIDE;
                        else
                            i_next = i_reg + 2'd1;
                    end
                endcase
            end
            S_DECIDE:
            begin
                case (shape_reg)
                    SH_PLANE:  fail_ev = status.neg;
                    SH_SPHERE: fail_ev = inside_bit ? status.gt_r1 : status.lt_r1;
                    default:   fail_ev = inside_bit ? status.gt_rr : status.lt_rr;
                endcase
                pass_ev = !fail_ev;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_vis_next   = vis_reg;
                    out_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // end of one entry
        if (fail_ev)
        begin
            vis_next   = 1'b0;
            bad_next   = fail_bad;
            state_next = S_FIN;
        end
        else if (pass_ev)
        begin
            if (entry_reg + 5'd1 >= n_eff)
            begin
                vis_next   = 1'b1;
                bad_next   = 1'b0;
                state_next = S_FIN;
            end
            else
            begin
                entry_next = entry_reg + 5'd1;
                cnt_next   = '0;
                state_next = S_FETCH;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk and result registers
    always_ff @(posedge clk)
    begin
        shape_reg   <= shape_next;
        entry_reg   <= entry_next;
        cnt_reg     <= cnt_next;
        ph_reg      <= ph_next;
        i_reg       <= i_next;
        vis_reg     <= vis_next;
        bad_reg     <= bad_next;
        out_vis_reg <= out_vis_next;
        out_bad_reg <= out_bad_next;
    end

`ifndef ASSERT_OFF
    // state register stays one-hot
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    // the walk never goes past the checked entries
    a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH || state_reg == S_DISP) |-> (entry_reg < n_eff))
        else $error("entry walk beyond clip_count");

    // a finished walk lands in the output register
    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && (!out_valid_reg || out_ready)) |=>
        (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded");

    // a bad type always reports not visible
    a_bad_vis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_bad_reg && out_vis_reg))
        else $error("bad type reported visible");
`endif

endmodule

>>> hw/rtl/csg_clip_point_test.sv
// Clip-region point test. A load beat writes one word of the 16-entry clip
// table. A test beat walks entries 0 to clip_count-1 (clip_count capped at 16)
// one at a time and stops at the first entry that fails or has no known shape.
// Each entry is fetched one word a cycle from the word memory; then three
// product terms run through the one shared multiplier, and a cone whose axial
// distance is in range adds a 17-step radial divider and the axis-distance sum.
// One item is in work at a time, and a finished result waits in the output
// register.
// Depends on cpt_pkg, cpt_ctrl and cpt_dpath.
module csg_clip_point_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpt_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cpt_pkg::out_beat_t out_data,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data
);
    import cpt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    cpt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_kind     (in_data.kind),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cmd         (cmd),
        .status      (status)
    );

    // table and arithmetic
    cpt_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

>>> tb/tb_csg_clip_point_test.sv
// testbench for csg_clip_point_test: loads the clip table, tests random points and
// compares every result beat with a Q16.16 prediction held in a scoreboard class
// depends on cpt_pkg and csg_clip_point_test
`timescale 1ns / 100ps

module tb_csg_clip_point_test;

    import cpt_pkg::*;

    localparam int          NUM_WORDS   = MAX_CLIPS * WORDS_PER_CLIP;
    localparam longint      CYCLE_LIMIT = 20000000;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          IDLE_TAIL   = 40;
    localparam int          PHASE_BEATS = 62;
    localparam logic [3:0]  TY_PLANE    = 4'(1 << T_PLANE);
    localparam logic [3:0]  TY_SPHERE   = 4'(1 << T_SPHERE);
    localparam logic [3:0]  TY_CONE     = 4'(1 << T_CONE);
    localparam logic [3:0]  TY_INSIDE   = 4'(1 << T_INSIDE);
    localparam logic        KIND_LOAD   = 1'b0;
    localparam logic        KIND_TEST   = 1'b1;

    // clip table predictor and store of expected visibility results
    class clip_scoreboard;
        logic [3:0]  shape_bits[MAX_CLIPS];
        logic [31:0] table_words[NUM_WORDS];
        int unsigned walk_len;
        out_beat_t   pending_vis[$];
        int          mismatches;

        function new();
            walk_len = 0;
            mismatches = 0;
        endfunction

        function void set_count(logic [4:0] v);
            walk_len = {27'd0, v};
        endfunction

        function longint wd(int e, logic [3:0] slot);
            return longint'($signed(table_words[e * WORDS_PER_CLIP + int'(slot)]));
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // product with floor shift back to Q16.16
        function longint qmul(longint a, longint b);
            return (a * b) >>> 16;
        endfunction

        // 1 pass, 0 fail, -1 unknown shape
        function int entry_passes(int e, longint p[3]);
            logic [3:0] t;
            logic       ins;
            longint     v[3];
            longint     dot, d, r1, r2, len, ap, pct, r, rr, axis, diff;
            t = shape_bits[e];
            ins = t[T_INSIDE];
            dot = 0;
            d = 0;
            for (int i = 0; i < 3; i++)
                v[i] = clamp32(p[i] - wd(e, W_CENTER + 4'(i)));
            if (t[T_PLANE])
            begin
                for (int i = 0; i < 3; i++)
                    dot += qmul(v[i], wd(e, W_NORMAL + 4'(i)));
                return (dot < 0) ? 0 : 1;
            end
            if (t[T_SPHERE])
            begin
                r1 = wd(e, W_R1);
                for (int i = 0; i < 3; i++)
                    d += qmul(v[i], v[i]);
                if (ins)
                    return (d > r1) ? 0 : 1;
                return (d < r1) ? 0 : 1;
            end
            if (t[T_CONE])
            begin
                len = wd(e, W_LEN);
                r1 = wd(e, W_R1);
                r2 = wd(e, W_R2);
                for (int i = 0; i < 3; i++)
                begin
                    ap = clamp32(p[i] - wd(e, W_APEX + 4'(i)));
                    dot += qmul(ap, wd(e, W_NORMAL + 4'(i)));
                end
                if (dot < 0 || dot > len)
                    return ins ? 0 : 1;
                // zero length with t at zero takes the apex radius
                pct = (len > 0) ? ((dot <<< 16) / len) : 0;
                r = clamp32(r1 + (((r2 - r1) * pct) >>> 16));
                rr = qmul(r, r);
                for (int i = 0; i < 3; i++)
                begin
                    axis = wd(e, W_APEX + 4'(i)) + qmul(dot, wd(e, W_NORMAL + 4'(i)));
                    diff = clamp32(axis - p[i]);
                    d += qmul(diff, diff);
                end
                if (ins)
                    return (d > rr) ? 0 : 1;
                return (d < rr) ? 0 : 1;
            end
            return -1;
        endfunction

        function void note_input(in_beat_t b);
            longint    p[3];
            int        n, res;
            out_beat_t exp_vis;
            if (b.kind == KIND_LOAD)
            begin
                if (b.word_select == WS_TYPE)
                    shape_bits[b.clip_index] = b.word_value[3:0];
                else if (b.word_select <= 4'(WORDS_PER_CLIP))
                    table_words[int'(b.clip_index) * WORDS_PER_CLIP
                                + int'(b.word_select) - 1] = b.word_value;
                return;
            end
            p[0] = longint'(b.point_x);
            p[1] = longint'(b.point_y);
            p[2] = longint'(b.point_z);
            n = (walk_len > MAX_CLIPS) ? MAX_CLIPS : int'(walk_len);
            exp_vis.visible = 1'b1;
            exp_vis.bad_type = 1'b0;
            for (int e = 0; e < n; e++)
            begin
                res = entry_passes(e, p);
                if (res == 0)
                begin
                    exp_vis.visible = 1'b0;
                    break;
                end
                if (res < 0)
                begin
                    exp_vis.visible = 1'b0;
                    exp_vis.bad_type = 1'b1;
                    break;
                end
            end
            pending_vis.push_back(exp_vis);
        endfunction

        function void check(out_beat_t a);
            out_beat_t x;
            if (pending_vis.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat vis=%0b bad=%0b", a.visible, a.bad_type);
                return;
            end
            x = pending_vis.pop_front();
            if (a.visible !== x.visible || a.bad_type !== x.bad_type)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: visible exp %0b got %0b, bad_type exp %0b got %0b",
                             x.visible, a.visible, x.bad_type, a.bad_type);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_beat_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_beat_t  out_data;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;

    clip_scoreboard sb = new();
    longint         cyc = 0;
    int             burst_left = 0;
    bit             hold_req = 0;

    csg_clip_point_test u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat monitor and run limit
    always @(posedge clk)
    begin
        cyc++;
        if (rst_n && in_valid && in_ready)
            sb.note_input(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check(out_data);
        if (cyc > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int hold_left;
        int mode;
        int rx_cyc;
        hold_left = 0;
        mode = 0;
        rx_cyc = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cyc++;
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (rx_cyc % 256 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= (rx_cyc % 5 != 0);
                endcase
            end
        end
    end

    // one input beat, with bursts and random gaps in front
    task automatic send_beat(input in_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic load_word(input logic [3:0] idx, input logic [3:0] ws,
                             input logic [31:0] val);
        in_beat_t b;
        b.kind = KIND_LOAD;
        b.clip_index = idx;
        b.word_select = ws;
        b.word_value = val;
        b.point_x = $urandom;
        b.point_y = $urandom;
        b.point_z = $urandom;
        send_beat(b);
    endtask

    task automatic test_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        in_beat_t b;
        b.kind = KIND_TEST;
        b.clip_index = 4'($urandom);
        b.word_select = 4'($urandom);
        b.word_value = $urandom;
        b.point_x = x;
        b.point_y = y;
        b.point_z = z;
        send_beat(b);
    endtask

    // drain everything, then let trailing loads settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending_vis.size() != 0);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_count(input logic [4:0] v);
        wait_idle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        sb.set_count(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // signed value in +-mag units
    function automatic logic [31:0] near_fx(int mag);
        return 32'($urandom_range(0, 2 * (mag << 16))) - 32'(mag << 16);
    endfunction

    function automatic logic [31:0] rand_point();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return near_fx(3);
        if (sel < 9)
            return near_fx(12);
        return $urandom;
    endfunction

    function automatic logic [3:0] rand_shape();
        int sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return (($urandom_range(0, 1) != 0) ? TY_INSIDE : 4'd0);
            1, 2, 3: return TY_PLANE;
            4, 5: return TY_SPHERE;
            6, 7: return TY_SPHERE | TY_INSIDE;
            8, 9, 10: return TY_CONE;
            11, 12, 13: return TY_CONE | TY_INSIDE;
            default: return 4'($urandom_range(1, 15)) | TY_PLANE;
        endcase
    endfunction

    // full entry rewrite with content that fits the shape, now and then with one random word
    task automatic load_entry(input logic [3:0] idx, input logic [3:0] shape);
        logic [31:0] w[WORDS_PER_CLIP];
        int          ax;
        for (int i = 0; i < 3; i++)
        begin
            w[W_CENTER + i] = near_fx(3);
            w[W_NORMAL + i] = near_fx(1);
            w[W_APEX + i] = near_fx(2);
        end
        if (shape[T_CONE] && !shape[T_PLANE] && !shape[T_SPHERE]
            && $urandom_range(0, 1) != 0)
        begin
            // axis-aligned unit normal so points land in range often
            ax = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                w[W_NORMAL + i] = (i == ax) ? (($urandom_range(0, 1) != 0) ?
                                  32'h0001_0000 : 32'hFFFF_0000) : near_fx(0);
        end
        w[W_R1] = shape[T_SPHERE] ? 32'($urandom_range(0, 9 << 16))
                                  : 32'($urandom_range(0, 2 << 16));
        w[W_R2] = 32'($urandom_range(0, 2 << 16));
        w[W_LEN] = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(0, 4 << 16));
        if ($urandom_range(0, 19) == 0)
            w[$urandom_range(0, WORDS_PER_CLIP - 1)] = $urandom;
        load_word(idx, WS_TYPE, {$urandom} & 32'hFFFF_FFF0 | 32'(shape));
        for (int i = 0; i < WORDS_PER_CLIP; i++)
            load_word(idx, 4'(i + 1), w[i]);
    endtask

    // stimulus
    initial
    begin
        logic [4:0] counts[12];
        int sel;
        counts = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd2, 5'd16, 5'd8,
                   5'd0, 5'd17, 5'd3, 5'd12, 5'd6};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // whole table written before any walk
        for (int e = 0; e < MAX_CLIPS; e++)
            load_entry(4'(e), (e < 5) ? 4'(e + 1) | TY_PLANE : rand_shape());
        load_entry(4'd1, TY_SPHERE);
        load_entry(4'd2, TY_SPHERE | TY_INSIDE);
        load_entry(4'd3, TY_CONE);
        load_entry(4'd4, TY_CONE | TY_INSIDE);

        // empty walk with extreme points
        write_count(5'd0);
        test_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        test_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

        // count above table size, extremes saturate differences
        write_count(5'd31);
        test_point(32'd0, 32'd0, 32'd0);
        test_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        test_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

        // zero-length cone, point on the apex
        load_word(4'd0, WS_TYPE, 32'(TY_CONE | TY_INSIDE));
        for (int i = 0; i < 3; i++)
        begin
            load_word(4'd0, 4'(W_APEX + 1 + i), 32'd0);
            load_word(4'd0, 4'(W_NORMAL + 1 + i), 32'd0);
        end
        load_word(4'd0, 4'(W_LEN + 1), 32'd0);
        load_word(4'd0, 4'(W_R1 + 1), 32'h0001_0000);
        write_count(5'd1);
        test_point(32'd0, 32'd0, 32'd0);
        load_word(4'd0, WS_TYPE, 32'(TY_CONE));
        test_point(32'd0, 32'd0, 32'd0);

        // unknown shapes; out-of-range word selects are dropped
        load_word(4'd0, WS_TYPE, 32'(TY_INSIDE));
        test_point(32'd0, 32'd0, 32'd0);
        load_word(4'd0, WS_TYPE, 32'hFFFF_FFF0);
        load_word(4'd0, 4'd13, $urandom);
        load_word(4'd0, 4'd15, $urandom);
        test_point(near_fx(2), near_fx(2), near_fx(2));

        // random phases over several walk lengths
        for (int ph = 0; ph < 12; ph++)
        begin
            write_count(counts[ph]);
            if (ph == 3)
                hold_req = 1;
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    test_point(rand_point(), rand_point(), rand_point());
                else if (sel < 68)
                    load_entry(4'($urandom_range(0, MAX_CLIPS - 1)), rand_shape());
                else if (sel < 80)
                    load_word(4'($urandom), WS_TYPE, $urandom);
                else
                    load_word(4'($urandom), 4'($urandom),
                              ($urandom_range(0, 3) == 0) ? $urandom : near_fx(3));
            end
        end

        wait_idle();
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_dpath.sv
hw/rtl/cpt_ctrl.sv
hw/rtl/csg_clip_point_test.sv
tb/tb_csg_clip_point_test.sv
